FILE: hw/rtl/phro_pkg.sv
`default_nettype none

package phro_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_AXES      = 3;
  localparam int HASH_DEPTH    = 15;
  localparam int CFG_IDX_W     = 3;
  localparam int XS_SHIFT      = 16;
  localparam int MIX_SHIFT     = 8;

  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;
  localparam logic [31:0] MIX_MUL = 32'd1103515245;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Z = 3'd5;

  localparam logic signed [31:0] MIN_RESET = 32'sd0;
  localparam logic signed [31:0] MAX_RESET = 32'sd65536;

  typedef logic [NUM_AXES-1:0][31:0] vec3_t;

  typedef struct packed {
    logic signed [31:0] lo;
    logic               neg;
    logic [32:0]        mag;
  } axis_cfg_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    vec3_t       pos;
  } hash_stage_t;

  typedef struct packed {
    logic  valid;
    vec3_t h;
    vec3_t pos;
  } hash_out_t;

  function automatic logic [31:0] mul32(input logic [31:0] x, input logic [31:0] y);
    logic [63:0] p;
    p = 64'(x) * 64'(y);
    return p[31:0];
  endfunction

  function automatic logic [31:0] xsh32(input logic [31:0] v);
    return v ^ (v >> XS_SHIFT);
  endfunction

  function automatic logic [31:0] mix32(input logic [31:0] v);
    return mul32((v >> MIX_SHIFT) ^ v, MIX_MUL);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/phro_cfg.sv
`default_nettype none

module phro_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [phro_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data,
  output phro_pkg::axis_cfg_t [phro_pkg::NUM_AXES-1:0] axis_cfg
);
  import phro_pkg::*;

  logic [NUM_AXES-1:0][31:0] min_val;
  logic [NUM_AXES-1:0][31:0] max_val;
  logic [NUM_AXES-1:0][32:0] diff;
  logic [NUM_AXES-1:0][32:0] mag_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        min_val[i] <= MIN_RESET;
        max_val[i] <= MAX_RESET;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_X: min_val[0] <= cfg_data;
        REG_MIN_Y: min_val[1] <= cfg_data;
        REG_MIN_Z: min_val[2] <= cfg_data;
        REG_MAX_X: max_val[0] <= cfg_data;
        REG_MAX_Y: max_val[1] <= cfg_data;
        REG_MAX_Z: max_val[2] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      diff[i]     = {max_val[i][31], max_val[i]} - {min_val[i][31], min_val[i]};
      mag_next[i] = diff[i][32] ? (33'd0 - diff[i]) : diff[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      axis_cfg[i].lo  <= min_val[i];
      axis_cfg[i].neg <= diff[i][32];
      axis_cfg[i].mag <= mag_next[i];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/phro_hash.sv
`default_nettype none

module phro_hash #(
  parameter int FRAC_BITS = phro_pkg::FRAC_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire phro_pkg::vec3_t in_pos,
  output phro_pkg::hash_out_t  hout
);
  import phro_pkg::*;

  logic [HASH_DEPTH-1:0] vld;
  hash_stage_t           st  [HASH_DEPTH];
  hash_stage_t           nxt [HASH_DEPTH];
  logic [NUM_AXES-1:0][32:0] mag;
  logic [NUM_AXES-1:0][32:0] shf;
  logic [NUM_AXES-1:0][32:0] tr;
  logic [31:0] xa, xb, xc;

  // truncate toward zero
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      mag[i] = in_pos[i][31] ? (33'd0 - {1'b1, in_pos[i]}) : {1'b0, in_pos[i]};
      shf[i] = mag[i] >> FRAC_BITS;
      tr[i]  = in_pos[i][31] ? (33'd0 - shf[i]) : shf[i];
    end
  end

  always_comb begin
    xa = xsh32(st[4].a);
    xb = xsh32(st[4].b);
    xc = xsh32(st[4].c);

    nxt[0].a   = tr[0][31:0];
    nxt[0].b   = tr[1][31:0];
    nxt[0].c   = tr[2][31:0];
    nxt[0].pos = in_pos;
    for (int i = 1; i < HASH_DEPTH; i++) begin
      nxt[i] = st[i-1];
    end

    nxt[1].a  = mul32(st[0].a, LCG_MUL) + LCG_ADD;
    nxt[1].b  = mul32(st[0].b, LCG_MUL) + LCG_ADD;
    nxt[1].c  = mul32(st[0].c, LCG_MUL) + LCG_ADD;
    nxt[2].a  = st[1].a + mul32(st[1].b, st[1].c);
    nxt[3].b  = st[2].b + mul32(st[2].a, st[2].c);
    nxt[4].c  = st[3].c + mul32(st[3].b, st[3].a);
    nxt[5].a  = xa + mul32(xb, xc);
    nxt[5].b  = xb;
    nxt[5].c  = xc;
    nxt[6].b  = st[5].b + mul32(st[5].a, st[5].c);
    nxt[7].c  = st[6].c + mul32(st[6].b, st[6].a);
    nxt[8].a  = st[7].a ^ (st[7].b << 2) ^ (st[7].c >> 2);
    nxt[9].b  = mix32(st[8].a);
    nxt[10].b = mix32(st[9].b);
    nxt[11].b = mix32(st[10].b);
    nxt[12].c = mix32(st[11].b);
    nxt[13].c = mix32(st[12].c);
    nxt[14].c = mix32(st[13].c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[HASH_DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < HASH_DEPTH; i++) begin
        st[i] <= nxt[i];
      end
    end
  end

  assign hout.valid = vld[HASH_DEPTH-1];
  assign hout.h[0]  = st[HASH_DEPTH-1].a;
  assign hout.h[1]  = st[HASH_DEPTH-1].b;
  assign hout.h[2]  = st[HASH_DEPTH-1].c;
  assign hout.pos   = st[HASH_DEPTH-1].pos;

endmodule

`default_nettype wire

FILE: hw/rtl/phro_scale.sv
`default_nettype none

module phro_scale (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire phro_pkg::hash_out_t hin,
  input  wire phro_pkg::axis_cfg_t [phro_pkg::NUM_AXES-1:0] axis_cfg,
  output logic                     res_valid,
  output phro_pkg::vec3_t          res
);
  import phro_pkg::*;

  logic        va, vb;
  logic [64:0] prod [NUM_AXES];
  vec3_t       pos_a, pos_b;
  logic [NUM_AXES-1:0][32:0] hi;
  logic [NUM_AXES-1:0][32:0] hi_ceil;
  logic [NUM_AXES-1:0][33:0] lo_ext;
  logic [NUM_AXES-1:0][33:0] off_next;
  logic [NUM_AXES-1:0][33:0] off;
  logic signed [34:0] sum [NUM_AXES];

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      hi[i]       = prod[i][64:32];
      hi_ceil[i]  = hi[i] + 33'(|prod[i][31:0]);
      lo_ext[i]   = {{2{axis_cfg[i].lo[31]}}, axis_cfg[i].lo};
      off_next[i] = axis_cfg[i].neg ? (lo_ext[i] - {1'b0, hi_ceil[i]})
                                    : (lo_ext[i] + {1'b0, hi[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (en) begin
      va <= hin.valid;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        prod[i] <= 65'(hin.h[i]) * 65'(axis_cfg[i].mag);
      end
      pos_a <= hin.pos;
      off   <= off_next;
      pos_b <= pos_a;
    end
  end

  // saturate
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      sum[i] = $signed({{3{pos_b[i][31]}}, pos_b[i]}) + $signed({off[i][33], off[i]});
      if (sum[i] > 35'sd2147483647) begin
        res[i] = 32'h7fff_ffff;
      end else if (sum[i] < -35'sd2147483648) begin
        res[i] = 32'h8000_0000;
      end else begin
        res[i] = sum[i][31:0];
      end
    end
  end

  assign res_valid = vb;

endmodule

`default_nettype wire

FILE: hw/rtl/position_hash_random_offset.sv
`default_nettype none
// Per-point pseudo-random offset.
// Input channel: in_valid/in_stall with pos_x, pos_y, pos_z (signed Q16.16). A point
// is transferred when in_valid is high and in_stall is low. Output channel:
// out_valid/out_stall with out_x, out_y, out_z, transferred when out_valid is high
// and out_stall is low. Each point gives exactly one result, in order.
// Configuration: cfg_valid/cfg_ready with cfg_index (0..5: min x/y/z, max x/y/z)
// and cfg_data; cfg_ready is always high, unknown indexes are ignored. Write only
// while no point is in flight.
// Throughput: one point per cycle while in_stall is low. The input transfer edge
// loads the first of 15 hash stages (at most one 32-bit multiply in series per
// stage), then a multiply stage and an offset stage for scaling, then the output
// register.
// Reset (rst, synchronous) empties the pipeline and sets min to 0 and max to 1.0.
// While out_stall holds a result, one more result is caught in a skid register;
// in_stall then rises and the whole pipeline holds until the output drains.
module position_hash_random_offset #(
  parameter int FRAC_BITS = phro_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [31:0]                    pos_x,
  input  wire logic [31:0]                    pos_y,
  input  wire logic [31:0]                    pos_z,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [31:0]                         out_x,
  output logic [31:0]                         out_y,
  output logic [31:0]                         out_z,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [phro_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data
);
  import phro_pkg::*;

  axis_cfg_t [NUM_AXES-1:0] axis_cfg;
  hash_out_t hout;
  vec3_t     in_pos;
  vec3_t     sc_res;
  vec3_t     skid;
  vec3_t     out_data;
  logic      sc_valid;
  logic      skid_full;
  logic      en;
  logic      in_xfer;

  assign en       = !skid_full;
  assign in_stall = skid_full;
  assign in_xfer  = in_valid && !in_stall;

  assign in_pos[0] = pos_x;
  assign in_pos[1] = pos_y;
  assign in_pos[2] = pos_z;

  phro_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .axis_cfg  (axis_cfg)
  );

  phro_hash #(
    .FRAC_BITS (FRAC_BITS)
  ) u_hash (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_xfer),
    .in_pos   (in_pos),
    .hout     (hout)
  );

  phro_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .hin       (hout),
    .axis_cfg  (axis_cfg),
    .res_valid (sc_valid),
    .res       (sc_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= skid_full || (en && sc_valid);
      skid_full <= 1'b0;
    end else if (en && sc_valid) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_data <= skid_full ? skid : sc_res;
    end else if (en && sc_valid) begin
      skid <= sc_res;
    end
  end

  assign out_x = out_data[0];
  assign out_y = out_data[1];
  assign out_z = out_data[2];

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid register full while output register empty");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without a stalled output");

  a_hold_tail: assert property (@(posedge clk) disable iff (rst)
    (sc_valid && skid_full) |=> (sc_valid && $stable(sc_res)))
    else $error("pipeline tail changed while held");
`endif

endmodule

`default_nettype wire
